/* hdl/stq_pkg.sv */
// stq_pkg: shared types and codes for the sleep timer queue
// request and response beat layouts, operation and status codes, unit result
// no dependencies
`default_nettype none

package stq_pkg;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int TID_W    = 16;
  localparam int REM_W    = 16;
  localparam int TICK_W   = 8;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SLEEP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd4;

  // request beat
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  task_id;
    logic [REM_W-1:0]  sleep_count;
    logic [TICK_W-1:0] tick_count;
  } stq_req_t;

  // response beat
  typedef struct packed {
    logic [TID_W-1:0]    out_id;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic [OCC_W-1:0]    occupancy;
    logic [TID_W-1:0]    head_id;
  } stq_rsp_t;

  // result of the shared decrement and compare unit
  typedef struct packed {
    logic             match;
    logic             expired;
    logic [REM_W-1:0] rem_left;
  } stq_alu_t;

endpackage

`default_nettype wire

/* hdl/stq_ram.sv */
// stq_ram: simple dual port memory, one write and one registered read per cycle
// depends on nothing
`default_nettype none

module stq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/stq_alu.sv */
// stq_alu: shared saturating decrement and id compare used by every scan step
// depends on stq_pkg
`default_nettype none

module stq_alu #(
  parameter int ID_BITS = 16
) (
  input  logic [stq_pkg::REM_W-1:0]  rem,
  input  logic [stq_pkg::TICK_W-1:0] ticks,
  input  logic [ID_BITS-1:0]         id,
  input  logic [ID_BITS-1:0]         key,
  output stq_pkg::stq_alu_t          res
);
  import stq_pkg::*;

  logic [REM_W-1:0] ticks_ext;

  assign ticks_ext = REM_W'(ticks);

  // saturate at zero, expired once nothing is left
  always_comb begin
    res.expired  = (rem <= ticks_ext);
    res.rem_left = res.expired ? '0 : rem - ticks_ext;
    res.match    = (id == key);
  end

endmodule

`default_nettype wire

/* hdl/sleep_timer_queue_unit.sv */
// sleep_timer_queue_unit: arrival-ordered queue of sleeping tasks with tick expiry
// depends on stq_pkg, stq_ram, stq_alu
//
//   channel  direction  handshake               beat
//   req      in         req_valid / req_stall   stq_req_t (func, task_id, sleep_count, tick_count)
//   rsp      out        rsp_valid / rsp_stall   stq_rsp_t (out_id, status, last, occupancy, head_id)
//
// enqueue goes straight to the put state, and dequeue passes a data state first
// when a new head must be fetched; the put state loads the response beat
// search and tick walk the queue through one memory read port and the shared
// decrement/compare unit, then the put state loads a single response beat, or,
// for tick expiries, one beat per expired id read back from a side buffer
// req_stall is high whenever the sequencer is busy; rsp_stall only holds the
// response register and the sequencer behind it
// synchronous reset empties the queue; the stores need no clearing pass
`default_nettype none

module sleep_timer_queue_unit #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  stq_pkg::stq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output stq_pkg::stq_rsp_t rsp
);
  import stq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = ID_BITS + REM_W;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DQ_DAT = 3'd2;
  localparam logic [2:0] S_XRD    = 3'd3;
  localparam logic [2:0] S_XDAT   = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // control state
  logic [2:0]    state;
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic [PW-1:0] rp;
  logic [PW-1:0] wp;
  logic [CW-1:0] issued;
  logic [CW-1:0] keep;
  logic [CW-1:0] nexp;
  logic [CW-1:0] k;
  logic          d_v;
  logic          found;

  // payload state
  logic [ID_BITS-1:0]  hid;
  logic [ID_BITS-1:0]  key;
  logic [TICK_W-1:0]   ticks;
  logic [FUNC_W-1:0]   op;
  logic [ID_BITS-1:0]  res_id;
  logic [STATUS_W-1:0] res_status;
  logic                res_last;

  // memory ports
  logic               mw_en;
  logic [PW-1:0]      mw_addr;
  logic [MW-1:0]      mw_data;
  logic               mr_en;
  logic [PW-1:0]      mr_addr;
  logic [MW-1:0]      mr_data;
  logic               xw_en;
  logic [PW-1:0]      xw_addr;
  logic [ID_BITS-1:0] xw_data;
  logic               xr_en;
  logic [PW-1:0]      xr_addr;
  logic [ID_BITS-1:0] xr_data;

  logic               accept;
  logic               slot_free;
  logic               scan_done;
  logic [31:0]        req_id32;
  logic [ID_BITS-1:0] req_id;
  logic [ID_BITS-1:0] scan_id;
  logic [REM_W-1:0]   scan_rem;
  logic [31:0]        res_id32;
  logic [31:0]        hid32;
  logic [31:0]        count32;
  stq_alu_t           alu;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign scan_done = (issued == count) && !d_v;

  assign req_id32 = 32'(req.task_id);
  assign req_id   = req_id32[ID_BITS-1:0];
  assign scan_id  = mr_data[ID_BITS-1:0];
  assign scan_rem = mr_data[MW-1:ID_BITS];
  assign res_id32 = 32'(res_id);
  assign hid32    = 32'(hid);
  assign count32  = 32'(count);

  // entry store: {remaining, id}
  stq_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mw_en),
    .waddr (mw_addr),
    .wdata (mw_data),
    .re    (mr_en),
    .raddr (mr_addr),
    .rdata (mr_data)
  );

  // expired ids of the current tick, oldest first
  stq_ram #(.WIDTH(ID_BITS), .DEPTH(DEPTH)) u_expired (
    .clk   (clk),
    .we    (xw_en),
    .waddr (xw_addr),
    .wdata (xw_data),
    .re    (xr_en),
    .raddr (xr_addr),
    .rdata (xr_data)
  );

  // shared decrement and compare
  stq_alu #(.ID_BITS(ID_BITS)) u_alu (
    .rem   (scan_rem),
    .ticks (ticks),
    .id    (scan_id),
    .key   (key),
    .res   (alu)
  );

  // memory port steering
  always_comb begin
    mw_en   = 1'b0;
    mw_addr = tail;
    mw_data = {req.sleep_count, req_id};
    mr_en   = 1'b0;
    mr_addr = wrap_inc(head);
    xw_en   = 1'b0;
    xw_addr = nexp[PW-1:0];
    xw_data = scan_id;
    xr_en   = 1'b0;
    xr_addr = k[PW-1:0];
    case (state)
      S_IDLE: begin
        if (accept && req.func == FUNC_ENQ && req.sleep_count != '0 && count != FULL) begin
          mw_en = 1'b1;
        end
        if (accept && req.func == FUNC_DEQ && count > CW'(1)) begin
          mr_en = 1'b1;
        end
      end
      S_SCAN: begin
        if (issued != count) begin
          mr_en   = 1'b1;
          mr_addr = rp;
        end
        // compaction writes trail the reads, so they never collide
        if (d_v && op == FUNC_TICK) begin
          if (alu.expired) begin
            xw_en = 1'b1;
          end else begin
            mw_en   = 1'b1;
            mw_addr = wp;
            mw_data = {alu.rem_left, scan_id};
          end
        end
      end
      S_XRD: begin
        xr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      d_v       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // response register: loaded from the put state, held while stalled
      rsp_valid <= (state == S_PUT && slot_free) || (rsp_valid && rsp_stall);
      case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req.func;
            key        <= req_id;
            ticks      <= (req.tick_count == '0) ? TICK_W'(1) : req.tick_count;
            res_id     <= '0;
            res_last   <= 1'b1;
            rp         <= head;
            wp         <= head;
            issued     <= '0;
            keep       <= '0;
            nexp       <= '0;
            found      <= 1'b0;
            d_v        <= 1'b0;
            case (req.func)
              FUNC_ENQ: begin
                state <= S_PUT;
                if (req.sleep_count == '0) begin
                  res_status <= ST_NO_SLEEP;
                end else if (count == FULL) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                  tail       <= wrap_inc(tail);
                  count      <= count + 1'b1;
                  if (count == '0) begin
                    hid <= req_id;
                  end
                end
              end
              FUNC_DEQ: begin
                if (count == '0) begin
                  res_status <= ST_NONE;
                  state      <= S_PUT;
                end else begin
                  res_status <= ST_OK;
                  res_id     <= hid;
                  head       <= wrap_inc(head);
                  count      <= count - 1'b1;
                  state      <= (count > CW'(1)) ? S_DQ_DAT : S_PUT;
                end
              end
              default: begin
                state <= S_SCAN;
              end
            endcase
          end
        end
        S_DQ_DAT: begin
          hid   <= scan_id;
          state <= S_PUT;
        end
        S_SCAN: begin
          // issue the next read
          if (issued != count) begin
            rp     <= wrap_inc(rp);
            issued <= issued + 1'b1;
          end
          d_v <= (issued != count);
          // process the entry read last cycle
          if (d_v) begin
            if (op == FUNC_TICK) begin
              if (alu.expired) begin
                nexp <= nexp + 1'b1;
              end else begin
                wp   <= wrap_inc(wp);
                keep <= keep + 1'b1;
                if (keep == '0) begin
                  hid <= scan_id;
                end
              end
            end else if (alu.match) begin
              found <= 1'b1;
            end
          end
          if (scan_done) begin
            if (op == FUNC_TICK) begin
              count <= keep;
              tail  <= wp;
              k     <= '0;
              if (nexp == '0) begin
                res_status <= ST_NONE;
                state      <= S_PUT;
              end else begin
                state <= S_XRD;
              end
            end else begin
              res_status <= found ? ST_PRESENT : ST_NONE;
              state      <= S_PUT;
            end
          end
        end
        S_XRD: begin
          state <= S_XDAT;
        end
        S_XDAT: begin
          res_id     <= xr_data;
          res_status <= ST_OK;
          res_last   <= ((k + 1'b1) == nexp);
          state      <= S_PUT;
        end
        S_PUT: begin
          if (slot_free) begin
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_XRD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response beat payload, occupancy and head taken after the operation
  always_ff @(posedge clk) begin
    if (state == S_PUT && slot_free) begin
      rsp.out_id    <= res_id32[TID_W-1:0];
      rsp.status    <= res_status;
      rsp.last      <= res_last;
      rsp.occupancy <= count32[OCC_W-1:0];
      rsp.head_id   <= (count != '0) ? hid32[TID_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire
